// ===== src/vwf_pkg.sv =====
`default_nettype none
package vwf_pkg;

  localparam int GLYPH_SLOTS     = 512;
  localparam int SLOT_W          = $clog2(GLYPH_SLOTS);
  localparam int CNT_W           = SLOT_W + 1;
  localparam int ATLAS_WIDTH     = 4096;
  localparam int HALF_W          = $clog2(ATLAS_WIDTH / 2);
  localparam int FONT_HEIGHT     = 16;
  localparam int ROW_W           = $clog2(FONT_HEIGHT);
  localparam int ATLAS_AW        = 15;
  localparam int ATLAS_BYTES     = 1 << ATLAS_AW;
  localparam int MAX_GLYPH_WIDTH = 16;
  localparam int MASK_W          = 16;
  localparam int ROW_BYTES       = MASK_W / 2 + 1;
  localparam int K_W             = $clog2(ROW_BYTES);
  localparam int NZ_W            = 2 * ROW_BYTES;

  localparam logic [15:0] SPACE_CODE  = 16'h0020;
  localparam logic [3:0]  SPACE_W_RST = 4'd3;
  localparam logic [3:0]  GAP_RST     = 4'd0;

  localparam logic CFG_SPACE_WIDTH = 1'b0;
  localparam logic CFG_CHAR_GAP    = 1'b1;

  typedef enum logic [1:0] {
    OP_GLYPH = 2'd0,
    OP_ATLAS = 2'd1,
    OP_PEN   = 2'd2,
    OP_DRAW  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH,
    S_FETCH,
    S_DRAIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        char_code;
    logic [8:0]         table_index;
    logic [4:0]         glyph_width;
    logic [11:0]        atlas_column;
    logic [14:0]        atlas_address;
    logic [7:0]         atlas_byte;
    logic signed [11:0] pen_x;
    logic signed [11:0] pen_y;
  } in_t;

  typedef struct packed {
    logic signed [11:0] row_y;
    logic signed [11:0] left_x;
    logic [15:0]        row_mask;
    logic [4:0]         advance;
    logic               glyph_found;
    logic               last_row;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] key;
    logic [4:0]  wide;
    logic [11:0] column;
  } tab_ent_t;

  typedef struct packed {
    logic accept;
    logic clr_wr;
    logic cnt_clr;
    logic tab_rd;
    logic atl_rd;
    logic k_clr;
    logic row_clr;
    logic row_inc;
    logic emit;
    logic pen_adv;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_space;
    logic hit;
    logic miss;
    logic k_last;
    logic row_last;
    logic found;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/vwf_ctrl.sv =====
`default_nettype none
module vwf_ctrl
  import vwf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] opcode,
  input  wire sts_t       sts,
  output cmd_t            cmd,
  output logic            busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
        if (start && opcode == OP_DRAW) begin
          cmd.cnt_clr = 1'b1;
          cmd.k_clr   = 1'b1;
          cmd.row_clr = 1'b1;
          state_nxt   = sts.in_space ? S_EMIT : S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.tab_rd = 1'b1;
        if (sts.hit) begin
          state_nxt = S_FETCH;
        end else if (sts.miss) begin
          state_nxt = S_EMIT;
        end
      end
      S_FETCH: begin
        cmd.atl_rd = 1'b1;
        if (sts.k_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.row_last) begin
          cmd.pen_adv = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.row_inc = 1'b1;
          cmd.k_clr   = 1'b1;
          state_nxt   = sts.found ? S_FETCH : S_EMIT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/vwf_dpath.sv =====
`default_nettype none
module vwf_dpath
  import vwf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_t        in_data,
  input  wire cmd_t       cmd,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [3:0] cfg_data,
  output sts_t            sts,
  output logic            out_valid,
  output out_t            out_data
);

  tab_ent_t tab_mem [GLYPH_SLOTS];
  logic [7:0] atl_mem [ATLAS_BYTES];

  logic [3:0]       space_w_r, gap_r;
  logic [11:0]      pen_col_r, pen_row_r;
  logic [15:0]      code_r;
  logic             found_r;
  logic [4:0]       width_r;
  logic [11:0]      col0_r;
  logic [CNT_W-1:0] cnt_r;
  logic             tab_pend_r;
  tab_ent_t         tab_q_r;
  logic [K_W-1:0]   k_r, atl_k_r;
  logic             atl_pend_r;
  logic [7:0]       atl_q_r;
  logic [NZ_W-1:0]  nz_r;
  logic [ROW_W-1:0] row_r;
  out_t             out_r;
  logic             out_valid_r;

  logic             cnt_open;
  logic [4:0]       wide_clamp;
  logic [5:0]       adv_sum;
  logic [4:0]       adv;
  logic [HALF_W-1:0] col_half;
  logic [ATLAS_AW-1:0] atl_addr;
  logic [MASK_W-1:0] shifted, wmask, mask;
  logic             acc_glyph, acc_atlas, acc_pen;

  assign acc_glyph = cmd.accept && in_data.opcode == OP_GLYPH;
  assign acc_atlas = cmd.accept && in_data.opcode == OP_ATLAS;
  assign acc_pen   = cmd.accept && in_data.opcode == OP_PEN;
  assign cnt_open  = cnt_r < CNT_W'(GLYPH_SLOTS);

  assign sts.clr_last = cnt_r == CNT_W'(GLYPH_SLOTS - 1);
  assign sts.in_space = in_data.char_code == SPACE_CODE;
  assign sts.hit      = tab_pend_r && tab_q_r.valid && tab_q_r.key == code_r;
  assign sts.miss     = !cnt_open && !tab_pend_r;
  assign sts.k_last   = k_r == K_W'(ROW_BYTES - 1);
  assign sts.row_last = row_r == ROW_W'(FONT_HEIGHT - 1);
  assign sts.found    = found_r;

  assign wide_clamp = (tab_q_r.wide > 5'(MAX_GLYPH_WIDTH)) ? 5'(MAX_GLYPH_WIDTH)
                                                         : tab_q_r.wide;
  assign adv_sum  = 6'(width_r) + 6'(gap_r);
  assign adv      = adv_sum[5] ? 5'd31 : adv_sum[4:0];
  assign col_half = HALF_W'(col0_r[11:1] + HALF_W'(k_r));
  assign atl_addr = {row_r, col_half};
  assign shifted  = col0_r[0] ? nz_r[MASK_W:1] : nz_r[MASK_W-1:0];
  assign wmask    = MASK_W'((17'd1 << width_r) - 17'd1);
  assign mask     = found_r ? (shifted & wmask) : '0;

  // glyph table
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      tab_mem[cnt_r[SLOT_W-1:0]] <= '0;
    end else if (acc_glyph) begin
      tab_mem[in_data.table_index] <= {1'b1, in_data.char_code, in_data.glyph_width,
                                       in_data.atlas_column};
    end
    if (cmd.tab_rd && cnt_open) begin
      tab_q_r <= tab_mem[cnt_r[SLOT_W-1:0]];
    end
  end

  // atlas
  always_ff @(posedge clk) begin
    if (acc_atlas) begin
      atl_mem[in_data.atlas_address] <= in_data.atlas_byte;
    end
    if (cmd.atl_rd) begin
      atl_q_r <= atl_mem[atl_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_w_r   <= SPACE_W_RST;
      gap_r       <= GAP_RST;
      pen_col_r   <= '0;
      pen_row_r   <= '0;
      cnt_r       <= '0;
      tab_pend_r  <= 1'b0;
      atl_pend_r  <= 1'b0;
      k_r         <= '0;
      row_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SPACE_WIDTH: space_w_r <= cfg_data;
          CFG_CHAR_GAP:    gap_r     <= cfg_data;
          default:         gap_r     <= gap_r;
        endcase
      end
      if (acc_pen) begin
        pen_col_r <= in_data.pen_x;
        pen_row_r <= in_data.pen_y;
      end else if (cmd.pen_adv) begin
        pen_col_r <= pen_col_r + 12'(adv);
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if ((cmd.clr_wr || cmd.tab_rd) && cnt_open) begin
        cnt_r <= cnt_r + 1'b1;
      end
      tab_pend_r <= cmd.tab_rd && cnt_open;
      atl_pend_r <= cmd.atl_rd;
      if (cmd.k_clr) begin
        k_r <= '0;
      end else if (cmd.atl_rd) begin
        k_r <= k_r + 1'b1;
      end
      if (cmd.row_clr) begin
        row_r <= '0;
      end else if (cmd.row_inc) begin
        row_r <= row_r + 1'b1;
      end
      if (cmd.cnt_clr) begin
        found_r <= 1'b0;
      end else if (cmd.tab_rd && sts.hit) begin
        found_r <= 1'b1;
      end
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      code_r  <= in_data.char_code;
      width_r <= 5'(space_w_r);
    end else if (cmd.tab_rd && sts.hit) begin
      width_r <= wide_clamp;
      col0_r  <= tab_q_r.column;
    end
    atl_k_r <= k_r;
    if (atl_pend_r) begin
      nz_r[{atl_k_r, 1'b0}] <= atl_q_r[7:4] != 4'd0;
      nz_r[{atl_k_r, 1'b1}] <= atl_q_r[3:0] != 4'd0;
    end
    if (cmd.emit) begin
      out_r.row_y       <= pen_row_r + 12'(row_r);
      out_r.left_x      <= pen_col_r;
      out_r.row_mask    <= mask;
      out_r.advance     <= adv;
      out_r.glyph_found <= found_r;
      out_r.last_row    <= sts.row_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== src/vwf_glyph_row_renderer.sv =====
// channel  | handshake               | payload
// input    | start, busy             | in_data (in_t)
// result   | out_valid (strobe)      | out_data (out_t)
// config   | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// table, atlas and pen requests complete in the cycle they are taken, busy stays low
// a draw searches up to 512 table slots (one slot read per cycle), then makes
// 9 atlas byte reads for each glyph row
// a space or unknown code emits its 16 rows one per cycle
// after reset busy stays high while the table valid bits of all 512 slots are cleared
// results show for one cycle each, the receiver cannot stall them
`default_nettype none
module vwf_glyph_row_renderer
  import vwf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_t        in_data,
  output logic            out_valid,
  output out_t            out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [3:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  vwf_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_data.opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  vwf_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_empty_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.glyph_found |-> out_data.row_mask == '0)
    else $error("mask set for a missing glyph");

  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.opcode == OP_DRAW |=> busy)
    else $error("draw request did not raise busy");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_row |=> !out_valid)
    else $error("row result right after the last row");

  a_fetch_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.atl_rd |-> sts.found)
    else $error("atlas fetch without a matched glyph");

endmodule
`default_nettype wire
